/* rtl/assert_macros.svh */
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error(msg);

`endif

/* rtl/tcgw_pkg.sv */
// shared constants, types and helpers of the text console glyph writer
package tcgw_pkg;

  // font geometry (glyph count and row count are powers of two)
  localparam int GLYPH_COUNT    = 256;
  localparam int MAX_GLYPH_ROWS = 16;
  localparam int GLYPH_WIDTH    = 8;
  localparam int TAB_SPACES     = 4;

  localparam int GIDX_W   = $clog2(GLYPH_COUNT);
  localparam int ROW_W    = $clog2(MAX_GLYPH_ROWS);
  localparam int STORE_AW = $clog2(GLYPH_COUNT * MAX_GLYPH_ROWS);
  localparam int GW_SHIFT = $clog2(GLYPH_WIDTH);
  localparam int TC_W     = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  // field and register widths
  localparam int CUR_W   = 12;
  localparam int H_W     = 5;
  localparam int PITCH_W = 13;
  localparam int COL_W   = 9;
  localparam int LINE_W  = 12;
  localparam int OFF_W   = 24;
  localparam int PIX_W   = 32;
  localparam int REG_W   = 3;
  localparam int PROD_W  = CUR_W + PITCH_W;

  // working cursor widths: set-cursor can land far beyond the 12-bit range
  localparam int X_MAX = 511 * GLYPH_WIDTH + 4095 + GLYPH_WIDTH;
  localparam int Y_MAX = 4095 * MAX_GLYPH_ROWS + 4095 + 2 * MAX_GLYPH_ROWS;
  localparam int X_W   = $clog2(X_MAX + 1);
  localparam int Y_W   = $clog2(Y_MAX + 1);

  localparam logic [CUR_W-1:0] CUR_MAX = 12'd4095;

  // special character codes
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CMD_PRINT = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_SET   = 2'd2
  } cmd_e;

  typedef enum logic [REG_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_TOP    = 3'd2,
    REG_BOTTOM = 3'd3,
    REG_HEIGHT = 3'd4,
    REG_PITCH  = 3'd5,
    REG_INK    = 3'd6,
    REG_PAPER  = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRAP_X,
    OP_WRAP_Y,
    OP_CLAMP,
    OP_ADV_X,
    OP_ADV_Y,
    OP_HOME_X,
    OP_SETPOS
  } alu_op_e;

  typedef struct packed {
    logic [CUR_W-1:0] left;
    logic [CUR_W-1:0] right;
    logic [CUR_W-1:0] top;
    logic [CUR_W-1:0] bottom;
    logic [H_W-1:0]   height;
  } cur_cfg_t;

  // font store address of one glyph row
  function automatic logic [STORE_AW-1:0] font_addr(logic [7:0] code,
                                                    logic [ROW_W-1:0] row);
    logic [GIDX_W-1:0] gidx;
    gidx = GIDX_W'(code);
    return STORE_AW'(gidx) * STORE_AW'(MAX_GLYPH_ROWS) + STORE_AW'(row);
  endfunction

endpackage

/* rtl/tcgw_if.sv */
// command and glyph row channel interfaces
interface tcgw_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [3:0] glyph_row;
  logic [7:0] glyph_bits;
  logic [8:0] cell_column;
  logic [11:0] cell_line;

  modport source (output valid, command, char_code, glyph_row, glyph_bits,
                  cell_column, cell_line, input ready);
  modport sink (input valid, command, char_code, glyph_row, glyph_bits,
                cell_column, cell_line, output ready);
endinterface

interface tcgw_row_if;
  logic        valid;
  logic        ready;
  logic [23:0] row_offset;
  logic [31:0] pixel_0;
  logic [31:0] pixel_1;
  logic [31:0] pixel_2;
  logic [31:0] pixel_3;
  logic [31:0] pixel_4;
  logic [31:0] pixel_5;
  logic [31:0] pixel_6;
  logic [31:0] pixel_7;
  logic        last_row;

  modport source (output valid, row_offset, pixel_0, pixel_1, pixel_2, pixel_3,
                  pixel_4, pixel_5, pixel_6, pixel_7, last_row, input ready);
  modport sink (input valid, row_offset, pixel_0, pixel_1, pixel_2, pixel_3,
                pixel_4, pixel_5, pixel_6, pixel_7, last_row, output ready);
endinterface

/* rtl/text_console_glyph_writer.sv */
// text console glyph writer top level: sequencer, registers and output stage
//
//   channel   dir  handshake         payload
//   cmd_i     in   valid / ready     command, char_code, glyph_row, glyph_bits,
//                                    cell_column, cell_line
//   row_o     out  valid / ready     row_offset, pixel_0..pixel_7, last_row
//   cfg       in   cfg_we_i          cfg_addr_i selects, cfg_wdata_i data
//
// the draw loop emits one glyph row per cycle while row_o accepts the rows.
// the cursor step unit does one wrap, clamp or move per cycle, so each trap is
// a wrap in x, then a wrap in y, then a clamp; one multiplier forms y * pitch
// or line * height.
// a stalled result transfer holds the draw loop on the current row.
// async active-low reset clears cursor, registers and control; the font store
// is not cleared and holds garbage until rows are loaded.
`include "assert_macros.svh"

module text_console_glyph_writer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tcgw_pkg::REG_W-1:0]   cfg_addr_i,
  input  logic [31:0]                  cfg_wdata_i,
  tcgw_cmd_if.sink                     cmd_i,
  tcgw_row_if.source                   row_o
);

  localparam int XW = tcgw_pkg::X_W;
  localparam int YW = tcgw_pkg::Y_W;
  localparam int HW = tcgw_pkg::H_W;
  localparam int RW = tcgw_pkg::ROW_W;
  localparam int GW = tcgw_pkg::GLYPH_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WX,
    S_WY,
    S_CL,
    S_MUL,
    S_SET,
    S_OFF,
    S_DRAW,
    S_ADVX,
    S_ADVY,
    S_HOME
  } state_e;

  // what follows the trap that is running
  typedef enum logic [1:0] {
    PH_PRE,
    PH_TAB,
    PH_POST
  } phase_e;

  // configuration registers
  logic [tcgw_pkg::CUR_W-1:0]   left_q, right_q, top_q, bottom_q;
  logic [HW-1:0]                height_q;
  logic [tcgw_pkg::PITCH_W-1:0] pitch_q;
  logic [tcgw_pkg::PIX_W-1:0]   ink_q, paper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= 12'd0;
      right_q  <= 12'd639;
      top_q    <= 12'd0;
      bottom_q <= 12'd479;
      height_q <= 5'd16;
      pitch_q  <= 13'd640;
      ink_q    <= 32'hFFFF_FFFF;
      paper_q  <= 32'h0000_0000;
    end else if (cfg_we_i) begin
      unique case (tcgw_pkg::reg_e'(cfg_addr_i))
        tcgw_pkg::REG_LEFT:   left_q   <= cfg_wdata_i[11:0];
        tcgw_pkg::REG_RIGHT:  right_q  <= cfg_wdata_i[11:0];
        tcgw_pkg::REG_TOP:    top_q    <= cfg_wdata_i[11:0];
        tcgw_pkg::REG_BOTTOM: bottom_q <= cfg_wdata_i[11:0];
        tcgw_pkg::REG_HEIGHT: height_q <= cfg_wdata_i[4:0];
        tcgw_pkg::REG_PITCH:  pitch_q  <= cfg_wdata_i[12:0];
        tcgw_pkg::REG_INK:    ink_q    <= cfg_wdata_i;
        tcgw_pkg::REG_PAPER:  paper_q  <= cfg_wdata_i;
      endcase
    end
  end

  // effective glyph height: zero acts as one, capped at the font row count
  logic [HW-1:0] h_eff;
  always_comb begin
    priority if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (height_q > HW'(tcgw_pkg::MAX_GLYPH_ROWS)) begin
      h_eff = HW'(tcgw_pkg::MAX_GLYPH_ROWS);
    end else begin
      h_eff = height_q;
    end
  end

  // sequencer state
  state_e                      state_q, state_d;
  phase_e                      phase_q, phase_d;
  logic                        roll_q, roll_d;
  logic                        tab_q, tab_d;
  logic [tcgw_pkg::TC_W-1:0]   tab_cnt_q, tab_cnt_d;
  logic [7:0]                  code_q, code_d;
  logic [RW-1:0]               row_q, row_d;
  logic [tcgw_pkg::COL_W-1:0]  col_q, col_d;
  logic [tcgw_pkg::LINE_W-1:0] line_q, line_d;
  logic [XW-1:0]               x_q, x_d;
  logic [YW-1:0]               y_q, y_d;
  logic [tcgw_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [tcgw_pkg::OFF_W-1:0]  off_q, off_d;

  // output stage
  logic                                 ovalid_q, ovalid_d;
  logic [tcgw_pkg::OFF_W-1:0]           ooff_q, ooff_d;
  logic [GW-1:0][tcgw_pkg::PIX_W-1:0]   opix_q, opix_d;
  logic                                 olast_q, olast_d;

  logic                        cmd_xfer;
  logic                        out_load;
  logic                        last_glyph;
  tcgw_pkg::alu_op_e           alu_op;
  tcgw_pkg::cur_cfg_t          cur_cfg;
  logic [XW-1:0]               alu_x;
  logic [YW-1:0]               alu_y;
  logic [tcgw_pkg::CUR_W-1:0]  mul_a;
  logic [tcgw_pkg::PITCH_W-1:0] mul_b;
  logic                        ram_we;
  logic [GW-1:0]               ram_rdata;
  logic [GW-1:0][tcgw_pkg::PIX_W-1:0] pix_new;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;

  // glyph row load goes straight to the font store on the command transfer
  assign ram_we = cmd_xfer && (cmd_i.command == tcgw_pkg::CMD_LOAD) &&
                  ({1'b0, cmd_i.glyph_row} < 5'(tcgw_pkg::MAX_GLYPH_ROWS));

  // read address follows the next row so data lines up with row_q
  tcgw_font_ram u_font_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tcgw_pkg::font_addr(cmd_i.char_code, RW'(cmd_i.glyph_row))),
    .wdata_i (cmd_i.glyph_bits),
    .raddr_i (tcgw_pkg::font_addr(code_q, row_d)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cur_cfg.left   = left_q;
    cur_cfg.right  = right_q;
    cur_cfg.top    = top_q;
    cur_cfg.bottom = bottom_q;
    cur_cfg.height = h_eff;
  end

  // step selected by the sequencer state
  always_comb begin
    unique case (state_q)
      S_WX:    alu_op = tcgw_pkg::OP_WRAP_X;
      S_WY:    alu_op = tcgw_pkg::OP_WRAP_Y;
      S_CL:    alu_op = tcgw_pkg::OP_CLAMP;
      S_SET:   alu_op = tcgw_pkg::OP_SETPOS;
      S_ADVX:  alu_op = tcgw_pkg::OP_ADV_X;
      S_ADVY:  alu_op = tcgw_pkg::OP_ADV_Y;
      S_HOME:  alu_op = tcgw_pkg::OP_HOME_X;
      default: alu_op = tcgw_pkg::OP_HOLD;
    endcase
  end

  tcgw_cursor_alu u_cursor_alu (
    .op_i   (alu_op),
    .roll_i (roll_q),
    .cfg_i  (cur_cfg),
    .col_i  (col_q),
    .prod_i (prod_q[YW-1:0]),
    .x_i    (x_q),
    .y_i    (y_q),
    .x_o    (alu_x),
    .y_o    (alu_y)
  );

  // shared multiplier: y * pitch when printing, line * height on set cursor
  assign mul_a = roll_q ? y_q[tcgw_pkg::CUR_W-1:0] : line_q;
  assign mul_b = roll_q ? pitch_q : tcgw_pkg::PITCH_W'(h_eff);

  // expand the glyph row, msb leftmost
  always_comb begin
    for (int i = 0; i < GW; i++) begin
      pix_new[i] = ram_rdata[GW-1-i] ? ink_q : paper_q;
    end
  end

  assign last_glyph = !tab_q ||
                      (tab_cnt_q == tcgw_pkg::TC_W'(tcgw_pkg::TAB_SPACES - 1));

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    roll_d    = roll_q;
    tab_d     = tab_q;
    tab_cnt_d = tab_cnt_q;
    code_d    = code_q;
    row_d     = row_q;
    col_d     = col_q;
    line_d    = line_q;
    x_d       = alu_x;
    y_d       = alu_y;
    prod_d    = prod_q;
    off_d     = off_q;
    ooff_d    = ooff_q;
    opix_d    = opix_q;
    olast_d   = olast_q;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_xfer) begin
          tab_cnt_d = '0;
          row_d     = '0;
          col_d     = cmd_i.cell_column;
          line_d    = cmd_i.cell_line;
          unique case (cmd_i.command)
            tcgw_pkg::CMD_PRINT: begin
              roll_d  = 1'b1;
              phase_d = PH_PRE;
              tab_d   = (cmd_i.char_code == tcgw_pkg::CHAR_TAB);
              code_d  = (cmd_i.char_code == tcgw_pkg::CHAR_TAB) ?
                        tcgw_pkg::CHAR_SPACE : cmd_i.char_code;
              state_d = S_WX;
            end
            tcgw_pkg::CMD_SET: begin
              roll_d  = 1'b0;
              phase_d = PH_POST;
              state_d = S_MUL;
            end
            default: begin
              // glyph load is done by the store write, unused code is dropped
            end
          endcase
        end
      end
      S_WX: state_d = S_WY;
      S_WY: state_d = S_CL;
      S_CL: begin
        unique case (phase_q)
          PH_PRE: begin
            priority if (code_q == tcgw_pkg::CHAR_LF) begin
              phase_d = PH_POST;
              state_d = S_ADVY;
            end else if (code_q == tcgw_pkg::CHAR_CR) begin
              phase_d = PH_POST;
              state_d = S_HOME;
            end else begin
              state_d = S_MUL;
            end
          end
          PH_TAB: begin
            if (last_glyph) begin
              // closing trap after the last space
              phase_d = PH_POST;
              state_d = S_WX;
            end else begin
              tab_cnt_d = tab_cnt_q + 1'b1;
              state_d   = S_MUL;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_MUL: begin
        prod_d  = tcgw_pkg::PROD_W'(mul_a) * tcgw_pkg::PROD_W'(mul_b);
        state_d = roll_q ? S_OFF : S_SET;
      end
      S_SET: state_d = S_WX;
      S_OFF: begin
        off_d   = tcgw_pkg::OFF_W'(x_q) + prod_q[tcgw_pkg::OFF_W-1:0];
        state_d = S_DRAW;
      end
      S_DRAW: begin
        if (!ovalid_q || row_o.ready) begin
          out_load = 1'b1;
          ooff_d   = off_q;
          opix_d   = pix_new;
          olast_d  = last_glyph && (HW'(row_q) == h_eff - HW'(1));
          off_d    = off_q + tcgw_pkg::OFF_W'(pitch_q);
          if (HW'(row_q) == h_eff - HW'(1)) begin
            row_d   = '0;
            state_d = S_ADVX;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      S_ADVX: begin
        phase_d = tab_q ? PH_TAB : PH_POST;
        state_d = S_WX;
      end
      S_ADVY: state_d = S_WX;
      S_HOME: state_d = S_WX;
      default: state_d = S_IDLE;
    endcase

    ovalid_d = ovalid_q;
    if (ovalid_q && row_o.ready) begin
      ovalid_d = 1'b0;
    end
    if (out_load) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_POST;
      roll_q    <= 1'b0;
      tab_q     <= 1'b0;
      tab_cnt_q <= '0;
      code_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      line_q    <= '0;
      x_q       <= '0;
      y_q       <= '0;
      prod_q    <= '0;
      off_q     <= '0;
      ovalid_q  <= 1'b0;
      ooff_q    <= '0;
      opix_q    <= '0;
      olast_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      roll_q    <= roll_d;
      tab_q     <= tab_d;
      tab_cnt_q <= tab_cnt_d;
      code_q    <= code_d;
      row_q     <= row_d;
      col_q     <= col_d;
      line_q    <= line_d;
      x_q       <= x_d;
      y_q       <= y_d;
      prod_q    <= prod_d;
      off_q     <= off_d;
      ovalid_q  <= ovalid_d;
      ooff_q    <= ooff_d;
      opix_q    <= opix_d;
      olast_q   <= olast_d;
    end
  end

  assign row_o.valid      = ovalid_q;
  assign row_o.row_offset = ooff_q;
  assign row_o.pixel_0    = opix_q[0];
  assign row_o.pixel_1    = opix_q[1];
  assign row_o.pixel_2    = opix_q[2];
  assign row_o.pixel_3    = opix_q[3];
  assign row_o.pixel_4    = opix_q[4];
  assign row_o.pixel_5    = opix_q[5];
  assign row_o.pixel_6    = opix_q[6];
  assign row_o.pixel_7    = opix_q[7];
  assign row_o.last_row   = olast_q;

  // draw row counter stays inside the glyph
  `ASSERT_CLK(a_row_in_glyph, clk_i, rst_ni, (state_q == S_DRAW) |-> (HW'(row_q) < h_eff), "draw row beyond glyph height")
  // cursor is trapped whenever the block waits for a command
  `ASSERT_CLK(a_cursor_trapped, clk_i, rst_ni, (state_q == S_IDLE) |-> ((x_q <= XW'(tcgw_pkg::CUR_MAX)) && (y_q <= YW'(tcgw_pkg::CUR_MAX))), "cursor out of range while idle")
  // a new row never overwrites a result still waiting for its transfer
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, out_load && ovalid_q && !row_o.ready, "pending result overwritten")

endmodule

/* rtl/tcgw_font_ram.sv */
// font store: one write port, one registered read port
module tcgw_font_ram (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [tcgw_pkg::STORE_AW-1:0]  waddr_i,
  input  logic [tcgw_pkg::GLYPH_WIDTH-1:0] wdata_i,
  input  logic [tcgw_pkg::STORE_AW-1:0]  raddr_i,
  output logic [tcgw_pkg::GLYPH_WIDTH-1:0] rdata_o
);

  logic [tcgw_pkg::GLYPH_WIDTH-1:0] mem [tcgw_pkg::GLYPH_COUNT * tcgw_pkg::MAX_GLYPH_ROWS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/tcgw_cursor_alu.sv */
// cursor step unit: one wrap, clamp or move step per cycle
module tcgw_cursor_alu (
  input  tcgw_pkg::alu_op_e               op_i,
  input  logic                            roll_i,
  input  tcgw_pkg::cur_cfg_t              cfg_i,
  input  logic [tcgw_pkg::COL_W-1:0]      col_i,
  input  logic [tcgw_pkg::Y_W-1:0]        prod_i,
  input  logic [tcgw_pkg::X_W-1:0]        x_i,
  input  logic [tcgw_pkg::Y_W-1:0]        y_i,
  output logic [tcgw_pkg::X_W-1:0]        x_o,
  output logic [tcgw_pkg::Y_W-1:0]        y_o
);

  localparam int XW = tcgw_pkg::X_W;
  localparam int YW = tcgw_pkg::Y_W;

  logic [XW:0]   x_plus_w;
  logic [YW:0]   y_plus_h;
  logic [YW-1:0] h_ext;

  assign h_ext    = YW'(cfg_i.height);
  assign x_plus_w = {1'b0, x_i} + (XW+1)'(tcgw_pkg::GLYPH_WIDTH);
  assign y_plus_h = {1'b0, y_i} + {1'b0, h_ext};

  always_comb begin
    x_o = x_i;
    y_o = y_i;
    unique case (op_i)
      tcgw_pkg::OP_HOLD: begin
      end
      tcgw_pkg::OP_WRAP_X: begin
        if (x_plus_w > (XW+1)'(cfg_i.right)) begin
          if (roll_i) begin
            x_o = XW'(cfg_i.left);
            y_o = y_i + h_ext;
          end else if (cfg_i.right >= tcgw_pkg::CUR_W'(tcgw_pkg::GLYPH_WIDTH)) begin
            x_o = XW'(cfg_i.right - tcgw_pkg::CUR_W'(tcgw_pkg::GLYPH_WIDTH));
          end else begin
            x_o = '0;
          end
        end
      end
      tcgw_pkg::OP_WRAP_Y: begin
        if (y_plus_h > (YW+1)'(cfg_i.bottom)) begin
          if (roll_i) begin
            x_o = XW'(cfg_i.left);
            y_o = YW'(cfg_i.top);
          end else if (y_i >= h_ext) begin
            y_o = y_i - h_ext;
          end else begin
            y_o = '0;
          end
        end
      end
      tcgw_pkg::OP_CLAMP: begin
        // raise to the region start, then cap at the cursor range
        if (x_i < XW'(cfg_i.left)) begin
          x_o = XW'(cfg_i.left);
        end else if (x_i > XW'(tcgw_pkg::CUR_MAX)) begin
          x_o = XW'(tcgw_pkg::CUR_MAX);
        end
        if (y_i < YW'(cfg_i.top)) begin
          y_o = YW'(cfg_i.top);
        end else if (y_i > YW'(tcgw_pkg::CUR_MAX)) begin
          y_o = YW'(tcgw_pkg::CUR_MAX);
        end
      end
      tcgw_pkg::OP_ADV_X: begin
        x_o = x_i + XW'(tcgw_pkg::GLYPH_WIDTH);
      end
      tcgw_pkg::OP_ADV_Y: begin
        y_o = y_i + h_ext;
      end
      tcgw_pkg::OP_HOME_X: begin
        x_o = XW'(cfg_i.left);
      end
      tcgw_pkg::OP_SETPOS: begin
        x_o = (XW'(col_i) << tcgw_pkg::GW_SHIFT) + XW'(cfg_i.left);
        y_o = prod_i + YW'(cfg_i.top);
      end
      default: begin
      end
    endcase
  end

endmodule
